// ===== design/cbpg_pkg.sv =====
// package for the cubic bezier point generator
// holds shared widths, constants, datapath opcodes and controller/datapath structs
// no dependencies
`default_nettype none

package cbpg_pkg;

  // coordinate and parameter formats
  localparam int unsigned COORD_W    = 16;              // signed q8.8
  localparam int unsigned N_COORDS   = 12;              // four 3d points
  localparam int unsigned N_AXES     = 3;
  localparam int unsigned N_WEIGHTS  = 4;
  localparam int unsigned U_W        = 17;              // unsigned q0.16, holds 1.0
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned IN_DATA_W  = N_COORDS * COORD_W;
  localparam int unsigned OUT_PAY_W  = N_AXES * COORD_W + IDX_W;
  localparam int unsigned OUT_DATA_W = ((OUT_PAY_W + 7) / 8) * 8;

  localparam logic [U_W-1:0]     ONE_Q16      = 17'h10000;
  localparam logic [U_W-1:0]     U_STEP_RESET = 17'd4096;
  localparam logic [COORD_W-1:0] COORD_BIAS   = 16'h8000;  // signed <-> offset binary

  localparam int unsigned DEFAULT_MAX_POINTS = 64;

  // shared multiplier and accumulator
  localparam int unsigned MUL_A_W = 33;                 // up to 2^32 (u^2 at u = 1.0)
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned W_W     = 49;                 // bernstein weight, q0.48 incl. 1.0
  localparam int unsigned W_LO_W  = 17;                 // weight split into hi / lo halves
  localparam int unsigned W_HI_W  = W_W - W_LO_W;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned RND_LSB = 47;                 // half lsb of the q0.48 sum

  // evaluation sequence, at most one multiply issued per step
  localparam int unsigned STEP_W = 6;
  localparam logic [STEP_W-1:0] STEP_COORD0    = 6'd7;   // first weight x coordinate product
  localparam logic [STEP_W-1:0] STEP_COORD_END = 6'd31;  // first step with nothing issued
  localparam logic [STEP_W-1:0] STEP_COMMIT0   = 6'd16;  // x sum complete in accumulator
  localparam logic [STEP_W-1:0] STEP_COMMIT1   = 6'd24;  // y sum complete
  localparam logic [STEP_W-1:0] STEP_LAST      = 6'd32;  // z sum complete

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_UU,
    MUL_VV,
    MUL_UV,
    MUL_U2U,
    MUL_V2V,
    MUL_UVV,
    MUL_UVU
  } mul_op_e;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_U2,
    WB_V2,
    WB_UV,
    WB_W3,
    WB_W0,
    WB_W1,
    WB_W2,
    WB_ACC_LD,
    WB_ACC_ADD
  } wb_op_e;

  typedef struct packed {
    logic             load_curve;
    logic             u_clear;
    logic             u_advance;
    mul_op_e          mul_op;
    logic             mul_wc;       // weight x coordinate product
    logic [1:0]       mul_wsel;
    logic             mul_hi;
    logic [1:0]       mul_axis;
    wb_op_e           wb_op;
    logic             wb_hi;
    logic             commit;
    logic [1:0]       commit_axis;
    logic             out_load;
    logic [IDX_W-1:0] out_index;
    logic             out_last;
  } cbpg_cmd_t;

  typedef struct packed {
    logic u_end;                    // next u would pass 1.0
  } cbpg_status_t;

endpackage

`default_nettype wire

// ===== design/cbpg_ctrl.sv =====
// controller of the cubic bezier point generator: sequences the shared multiplier
// per point and hands points to the output register; depends on cbpg_pkg
`default_nettype none

module cbpg_ctrl
  import cbpg_pkg::*;
#(
  parameter int unsigned MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire cbpg_status_t status_i,
  output cbpg_cmd_t         cmd_o
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic [STEP_W-1:0]  step_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               out_valid_q;

  logic               slot_free;
  logic               cnt_last;
  logic               pt_last;
  logic [STEP_W-1:0]  ws;
  logic [STEP_W-1:0]  j_iss;
  logic [STEP_W-1:0]  j_wb;
  logic [STEP_W-1:0]  csub;

  assign slot_free = !out_valid_q || out_ready_i;
  assign cnt_last  = (cnt_q == CNT_W'(MAX_POINTS - 1));
  assign pt_last   = status_i.u_end || cnt_last;
  assign ws        = step_q - 6'd1;
  assign j_iss     = step_q - STEP_COORD0;
  assign j_wb      = step_q - (STEP_COORD0 + 6'd1);
  assign csub      = step_q - STEP_COMMIT0;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.mul_op = MUL_NONE;
    cmd_o.wb_op  = WB_NONE;

    cmd_o.load_curve = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.u_clear    = cmd_o.load_curve;

    cmd_o.out_load  = (state_q == ST_EMIT) && slot_free;
    cmd_o.out_index = IDX_W'(cnt_q);
    cmd_o.out_last  = pt_last;
    cmd_o.u_advance = cmd_o.out_load && !pt_last;

    if (state_q == ST_CALC) begin
      // issue side: weights first, then weight x coordinate products
      priority if (step_q < STEP_COORD0) begin
        unique case (step_q[2:0])
          3'd0:    cmd_o.mul_op = MUL_UU;
          3'd1:    cmd_o.mul_op = MUL_VV;
          3'd2:    cmd_o.mul_op = MUL_UV;
          3'd3:    cmd_o.mul_op = MUL_U2U;
          3'd4:    cmd_o.mul_op = MUL_V2V;
          3'd5:    cmd_o.mul_op = MUL_UVV;
          3'd6:    cmd_o.mul_op = MUL_UVU;
          default: cmd_o.mul_op = MUL_NONE;
        endcase
      end else if (step_q < STEP_COORD_END) begin
        cmd_o.mul_wc   = 1'b1;
        cmd_o.mul_axis = j_iss[4:3];
        cmd_o.mul_wsel = j_iss[2:1];
        cmd_o.mul_hi   = !j_iss[0];
      end else begin
        cmd_o.mul_wc = 1'b0;
      end

      // write-back side trails the issue side through the product register
      priority if ((step_q != '0) && (step_q <= STEP_COORD0)) begin
        unique case (ws[2:0])
          3'd0:    cmd_o.wb_op = WB_U2;
          3'd1:    cmd_o.wb_op = WB_V2;
          3'd2:    cmd_o.wb_op = WB_UV;
          3'd3:    cmd_o.wb_op = WB_W3;
          3'd4:    cmd_o.wb_op = WB_W0;
          3'd5:    cmd_o.wb_op = WB_W1;
          3'd6:    cmd_o.wb_op = WB_W2;
          default: cmd_o.wb_op = WB_NONE;
        endcase
      end else if ((step_q > STEP_COORD0) && (step_q <= STEP_COORD_END)) begin
        cmd_o.wb_op = (j_wb[2:0] == 3'd0) ? WB_ACC_LD : WB_ACC_ADD;
        cmd_o.wb_hi = !j_wb[0];
      end else begin
        cmd_o.wb_op = WB_NONE;
      end

      cmd_o.commit      = (step_q == STEP_COMMIT0) || (step_q == STEP_COMMIT1) ||
                          (step_q == STEP_LAST);
      cmd_o.commit_axis = csub[4:3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CALC;
            step_q  <= '0;
            cnt_q   <= '0;
          end
        end
        ST_CALC: begin
          if (step_q == STEP_LAST) begin
            state_q <= ST_EMIT;
          end else begin
            step_q <= step_q + 6'd1;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (pt_last) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_CALC;
              step_q  <= '0;
              cnt_q   <= cnt_q + CNT_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/cbpg_datapath.sv =====
// datapath of the cubic bezier point generator: curve store, u accumulator,
// shared multiplier, weight registers, accumulator, rounding and output register; depends on cbpg_pkg
`default_nettype none

module cbpg_datapath
  import cbpg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [U_W-1:0]        cfg_wdata_i,
  input  wire logic [IN_DATA_W-1:0]  curve_i,
  input  wire cbpg_cmd_t             cmd_i,
  output cbpg_status_t               status_o,
  output logic [OUT_DATA_W-1:0]      out_tdata_o,
  output logic                       out_tlast_o
);

  logic [U_W-1:0]     u_step_q;
  logic [U_W-1:0]     u_q;
  logic [U_W:0]       u_next;
  logic [U_W-1:0]     v;

  logic [COORD_W-1:0] curve_q [N_COORDS];
  logic [MUL_A_W-1:0] u2_q, v2_q, uv_q;
  logic [W_W-1:0]     w_q [N_WEIGHTS];
  logic [PROD_W-1:0]  prod_q;
  logic [ACC_W-1:0]   acc_q;
  logic [COORD_W-1:0] res_q [N_AXES];

  logic [COORD_W-1:0] pt_x_q, pt_y_q, pt_z_q;
  logic [IDX_W-1:0]   idx_q;
  logic               last_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_d;
  logic [3:0]         coord_idx;
  logic [W_W-1:0]     w_sel;
  logic [PROD_W-1:0]  prod3;
  logic [ACC_W-1:0]   term;
  logic [U_W:0]       rnd;

  assign u_next        = {1'b0, u_q} + {1'b0, u_step_q};
  assign status_o.u_end = (u_next > {1'b0, ONE_Q16});
  assign v             = ONE_Q16 - u_q;   // u never passes 1.0 while evaluated

  // coordinate of weight i on axis k sits at 3i + k
  assign coord_idx = {2'b00, cmd_i.mul_wsel} + {1'b0, cmd_i.mul_wsel, 1'b0} +
                     {2'b00, cmd_i.mul_axis};
  assign w_sel     = w_q[cmd_i.mul_wsel];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.mul_wc) begin
      mul_a = cmd_i.mul_hi ? {1'b0, w_sel[W_W-1:W_LO_W]}
                           : {{(MUL_A_W-W_LO_W){1'b0}}, w_sel[W_LO_W-1:0]};
      mul_b = {1'b0, curve_q[coord_idx]};
    end else begin
      unique case (cmd_i.mul_op)
        MUL_UU:  begin mul_a = {16'b0, u_q}; mul_b = u_q; end
        MUL_VV:  begin mul_a = {16'b0, v};   mul_b = v;   end
        MUL_UV:  begin mul_a = {16'b0, u_q}; mul_b = v;   end
        MUL_U2U: begin mul_a = u2_q;         mul_b = u_q; end
        MUL_V2V: begin mul_a = v2_q;         mul_b = v;   end
        MUL_UVV: begin mul_a = uv_q;         mul_b = v;   end
        MUL_UVU: begin mul_a = uv_q;         mul_b = u_q; end
        default: begin mul_a = '0;           mul_b = '0;  end
      endcase
    end
  end

  assign prod_d = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
  assign prod3  = prod_q + {prod_q[PROD_W-2:0], 1'b0};

  // hi half of a weight carries 2^17, and the product stays below 2^47
  assign term = cmd_i.wb_hi ? {prod_q[ACC_W-W_LO_W-1:0], {W_LO_W{1'b0}}}
                            : {{(ACC_W-PROD_W){1'b0}}, prod_q};

  // round to nearest, ties up, from q0.48 weighted sum
  assign rnd = {1'b0, acc_q[ACC_W-1:RND_LSB]} + 18'd1;

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_step_q <= U_STEP_RESET;
      u_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        u_step_q <= cfg_wdata_i;
      end
      if (cmd_i.u_clear) begin
        u_q <= '0;
      end else if (cmd_i.u_advance) begin
        u_q <= u_next[U_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_curve) begin
      for (int i = 0; i < N_COORDS; i++) begin
        curve_q[i] <= curve_i[i*COORD_W +: COORD_W] ^ COORD_BIAS;
      end
    end

    prod_q <= prod_d;

    unique case (cmd_i.wb_op)
      WB_U2:      u2_q   <= prod_q[MUL_A_W-1:0];
      WB_V2:      v2_q   <= prod_q[MUL_A_W-1:0];
      WB_UV:      uv_q   <= prod_q[MUL_A_W-1:0];
      WB_W3:      w_q[3] <= prod_q[W_W-1:0];
      WB_W0:      w_q[0] <= prod_q[W_W-1:0];
      WB_W1:      w_q[1] <= prod3[W_W-1:0];
      WB_W2:      w_q[2] <= prod3[W_W-1:0];
      WB_ACC_LD:  acc_q  <= term;
      WB_ACC_ADD: acc_q  <= acc_q + term;
      default:    ;
    endcase

    if (cmd_i.commit) begin
      res_q[cmd_i.commit_axis] <= rnd[COORD_W:1] ^ COORD_BIAS;
    end

    if (cmd_i.out_load) begin
      pt_x_q <= res_q[0];
      pt_y_q <= res_q[1];
      pt_z_q <= res_q[2];
      idx_q  <= cmd_i.out_index;
      last_q <= cmd_i.out_last;
    end
  end

  assign out_tdata_o = {{(OUT_DATA_W-OUT_PAY_W){1'b0}}, idx_q, pt_z_q, pt_y_q, pt_x_q};
  assign out_tlast_o = last_q;

endmodule

`default_nettype wire

// ===== design/cubic_bezier_point_generator_top.sv =====
// top level of the cubic bezier point generator: stream ports and config register
// depends on cbpg_pkg, cbpg_ctrl and cbpg_datapath
`default_nettype none

// Takes one cubic bezier curve per input transaction (start point, two control
// points, end point, signed q8.8 x/y/z each) and emits the points
// P(u) = (1-u)^3 P0 + 3(1-u)^2 u C0 + 3(1-u) u^2 C1 + u^3 P1 for u = 0, u_step,
// 2 u_step, ... while u <= 1.0, at most MAX_POINTS points, each rounded to
// nearest q8.8 (ties up), with its index and tlast on the final point. The
// weights are exact in q0.48, so a point never leaves the coordinate range.
// All products go through one shared 33x17 multiplier: 7 products build the
// four bernstein weights and 24 more (hi and lo weight half per curve point
// and axis) form the sums; each point runs the evaluation sequence and is
// then moved into the output register once that register is free. A curve of
// n = min(floor(65536 / u_step) + 1, MAX_POINTS) points is evaluated point by
// point; the next curve is accepted once the last point of the
// previous one sits in the output register. u_step resets to 4096 (17 points).
module cubic_bezier_point_generator_top
  import cbpg_pkg::*;
#(
  parameter int unsigned MAX_POINTS = DEFAULT_MAX_POINTS  // 2 .. 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // u_step, unsigned q0.16
  input  wire logic                  cfg_we_i,
  input  wire logic [U_W-1:0]        cfg_wdata_i,
  // curve in: p0_x, p0_y, p0_z, c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, p1_x, p1_y, p1_z
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // point out: pt_x, pt_y, pt_z, pt_index, two zero pad bits
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast    // last_point
);

  cbpg_cmd_t    cmd;
  cbpg_status_t status;

  // sequencer: accept, evaluation steps, hand-off to the output register
  cbpg_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic, curve store and output payload
  cbpg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .curve_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_tdata_o (m_axis_tdata),
    .out_tlast_o (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== design/cbpg_checker.sv =====
// port-level checks for the cubic bezier point generator, bound to the top level
// depends on cbpg_pkg and cubic_bezier_point_generator_top
`default_nettype none

module cbpg_checker
  import cbpg_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  cfg_we_i,
  input wire logic [U_W-1:0]        cfg_wdata_i,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tlast
);

  // a stalled point keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output point changed while stalled");

  // no new curve while the current one still has points to come
  a_busy_mid_curve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("curve accepted before the previous one finished");

  // an accepted curve keeps the block busy for its evaluation
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after a curve transaction");

  // the first point of a fresh curve cannot show up the cycle after accept
  a_no_instant_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("point produced without evaluation");

endmodule

bind cubic_bezier_point_generator_top cbpg_checker u_cbpg_checker (.*);

`default_nettype wire
